FILE: design/rbcs_pkg.sv
// Shared types, codes and constants of the read base composition statistics block.
`default_nettype none

package rbcs_pkg;

    typedef enum logic [1:0] {
        KIND_BASE    = 2'd0,
        KIND_LEN_BIN = 2'd1,
        KIND_GC_BIN  = 2'd2,
        KIND_TOTAL   = 2'd3
    } kind_t;

    localparam int IDX_W   = 12;
    localparam int CHAR_W  = 8;
    localparam int VALUE_W = 48;
    localparam int PCT_W   = 7;
    localparam int CNT_W   = 48;
    localparam int LEN_W   = 32;
    localparam int BIN_W   = 32;
    localparam int GC_BINS = 101;
    localparam int GC_AW   = 7;

    // numerator 200*gc + len needs 40 bits for 32-bit counts
    localparam int NUM_W     = 40;
    localparam int DIV_STEPS = 7;
    localparam int STEP_W    = 3;
    localparam int GC_SCALE  = 200;

    localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
    localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};
    localparam logic [BIN_W-1:0] BIN_MAX = {BIN_W{1'b1}};

    // kind 3 selectors
    localparam logic [IDX_W-1:0] SEL_READS = 12'd0;
    localparam logic [IDX_W-1:0] SEL_BASES = 12'd1;
    localparam logic [IDX_W-1:0] SEL_A     = 12'd2;
    localparam logic [IDX_W-1:0] SEL_C     = 12'd3;
    localparam logic [IDX_W-1:0] SEL_G     = 12'd4;
    localparam logic [IDX_W-1:0] SEL_T     = 12'd5;

    localparam logic [CHAR_W-1:0] CH_A_UP = 8'h41;
    localparam logic [CHAR_W-1:0] CH_A_LO = 8'h61;
    localparam logic [CHAR_W-1:0] CH_C_UP = 8'h43;
    localparam logic [CHAR_W-1:0] CH_C_LO = 8'h63;
    localparam logic [CHAR_W-1:0] CH_G_UP = 8'h47;
    localparam logic [CHAR_W-1:0] CH_G_LO = 8'h67;
    localparam logic [CHAR_W-1:0] CH_T_UP = 8'h54;
    localparam logic [CHAR_W-1:0] CH_T_LO = 8'h74;

    function automatic logic [BIN_W-1:0] bin_inc(input logic [BIN_W-1:0] v);
        return (v != BIN_MAX) ? v + 1'b1 : v;
    endfunction

    function automatic logic [CNT_W-1:0] cnt_inc(input logic [CNT_W-1:0] v);
        return (v != CNT_MAX) ? v + 1'b1 : v;
    endfunction

endpackage

`default_nettype wire

FILE: design/rbcs_if.sv
// Valid/ready channel interfaces for base/query words and result words.
`default_nettype none

interface rbcs_in_if;
    import rbcs_pkg::*;
    logic              valid;
    logic              ready;
    logic [1:0]        kind;
    logic [CHAR_W-1:0] base_char;
    logic              end_of_read;
    logic [IDX_W-1:0]  index;

    modport source (output valid, kind, base_char, end_of_read, index, input ready);
    modport sink   (input valid, kind, base_char, end_of_read, index, output ready);
endinterface

interface rbcs_out_if;
    import rbcs_pkg::*;
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;
    logic               read_done;
    logic [PCT_W-1:0]   gc_percent;

    modport source (output valid, value, read_done, gc_percent, input ready);
    modport sink   (input valid, value, read_done, gc_percent, output ready);
endinterface

`default_nettype wire

FILE: design/read_base_composition_stats.sv
// Top level: per-read base counting, length and GC histograms, query readback.
//
// Takes one word at a time on req and answers each with one word on rsp. A length
// or GC bin query does one histogram memory read. A base that closes its read
// goes through the numerator multiply, the 7-step restoring divider for the GC
// percent, and the read-modify-write of both histogram memories. After reset a
// clearing pass zeroes both histograms, one bin per cycle, during which req is
// not ready. A result word waits in the output register while the next word is
// accepted and worked on.
`default_nettype none

module read_base_composition_stats
    import rbcs_pkg::*;
#(
    parameter int TOP_LENGTH_BIN = 4095
) (
    input  wire logic clk,
    input  wire logic rst_n,
    rbcs_in_if.sink   req,
    rbcs_out_if.source rsp
);

    localparam int LEN_DEPTH = TOP_LENGTH_BIN + 1;
    localparam int LEN_AW    = $clog2(LEN_DEPTH);
    localparam int CLR_DEPTH = (LEN_DEPTH > GC_BINS) ? LEN_DEPTH : GC_BINS;
    localparam int CLR_W     = $clog2(CLR_DEPTH);
    localparam logic [LEN_AW-1:0] TOP_BIN = LEN_AW'(TOP_LENGTH_BIN);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_QRD, S_MUL, S_DIV, S_GCRD, S_GCWR, S_DONE
    } state_t;

    state_t state_reg;

    logic [CLR_W-1:0]   clr_cnt_reg;
    logic [CNT_W-1:0]   count_a_reg, count_c_reg, count_g_reg, count_t_reg;
    logic [CNT_W-1:0]   base_total_reg;
    logic [LEN_W-1:0]   read_total_reg;
    logic [LEN_W-1:0]   cur_len_reg, cur_gc_reg;
    logic [LEN_W-1:0]   len_close_reg, gc_close_reg;
    logic [LEN_AW-1:0]  bin_reg;
    logic [NUM_W-1:0]   rem_reg, dsh_reg;
    logic [PCT_W-1:0]   quot_reg, pct_reg;
    logic [STEP_W-1:0]  step_reg;
    logic               q_gc_reg, q_hit_reg;

    logic [VALUE_W-1:0] res_value_reg;
    logic               res_done_reg;
    logic [PCT_W-1:0]   res_pct_reg;

    logic               out_valid_reg;
    logic [VALUE_W-1:0] out_value_reg;
    logic               out_done_reg;
    logic [PCT_W-1:0]   out_pct_reg;

    // histogram memories
    logic [BIN_W-1:0]  len_mem [LEN_DEPTH];
    logic [BIN_W-1:0]  gc_mem  [GC_BINS];
    logic [BIN_W-1:0]  len_q_reg, gc_q_reg;
    logic              len_we, len_re, gc_we, gc_re;
    logic [LEN_AW-1:0] len_waddr, len_raddr;
    logic [GC_AW-1:0]  gc_waddr, gc_raddr;
    logic [BIN_W-1:0]  len_wdata, gc_wdata;

    logic              accept;
    logic              is_a, is_c, is_g, is_t, len_open;
    logic [LEN_W-1:0]  len_next, gc_next;
    logic [LEN_AW-1:0] bin_next;
    logic [PCT_W-1:0]  pct_clamp;
    logic [CNT_W-1:0]  total_sel;
    logic              len_in_range, gc_in_range;

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;

    assign rsp.valid      = out_valid_reg;
    assign rsp.value      = out_value_reg;
    assign rsp.read_done  = out_done_reg;
    assign rsp.gc_percent = out_pct_reg;

    always_comb
    begin
        is_a     = (req.base_char == CH_A_UP) || (req.base_char == CH_A_LO);
        is_c     = (req.base_char == CH_C_UP) || (req.base_char == CH_C_LO);
        is_g     = (req.base_char == CH_G_UP) || (req.base_char == CH_G_LO);
        is_t     = (req.base_char == CH_T_UP) || (req.base_char == CH_T_LO);
        len_open = (cur_len_reg != LEN_MAX);
        len_next = len_open ? cur_len_reg + 1'b1 : cur_len_reg;
        // gc never exceeds len and only counts while len is open, so no saturation check here
        gc_next  = ((is_g || is_c) && len_open) ? cur_gc_reg + 1'b1 : cur_gc_reg;
        bin_next = (len_next > LEN_W'(TOP_LENGTH_BIN)) ? TOP_BIN : LEN_AW'(len_next);
        pct_clamp    = (quot_reg > PCT_MAX) ? PCT_MAX : quot_reg;
        len_in_range = (LEN_W'(req.index) <= LEN_W'(TOP_LENGTH_BIN));
        gc_in_range  = (req.index < IDX_W'(GC_BINS));
        case (req.index)
            SEL_READS: total_sel = CNT_W'(read_total_reg);
            SEL_BASES: total_sel = base_total_reg;
            SEL_A:     total_sel = count_a_reg;
            SEL_C:     total_sel = count_c_reg;
            SEL_G:     total_sel = count_g_reg;
            SEL_T:     total_sel = count_t_reg;
            default:   total_sel = '0;
        endcase
    end

    always_comb
    begin
        len_we    = 1'b0;
        len_re    = 1'b0;
        len_waddr = bin_reg;
        len_raddr = bin_next;
        len_wdata = bin_inc(len_q_reg);
        gc_we     = 1'b0;
        gc_re     = 1'b0;
        gc_waddr  = pct_reg;
        gc_raddr  = pct_clamp;
        gc_wdata  = bin_inc(gc_q_reg);
        case (state_reg)
            S_CLEAR:
            begin
                len_we    = ({1'b0, clr_cnt_reg} < (CLR_W + 1)'(LEN_DEPTH));
                len_waddr = clr_cnt_reg[LEN_AW-1:0];
                len_wdata = '0;
                gc_we     = ({1'b0, clr_cnt_reg} < (CLR_W + 1)'(GC_BINS));
                gc_waddr  = clr_cnt_reg[GC_AW-1:0];
                gc_wdata  = '0;
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    case (kind_t'(req.kind))
                        KIND_BASE:    len_re = req.end_of_read;
                        KIND_LEN_BIN:
                        begin
                            len_re    = 1'b1;
                            len_raddr = LEN_AW'(req.index);
                        end
                        KIND_GC_BIN:
                        begin
                            gc_re    = 1'b1;
                            gc_raddr = GC_AW'(req.index);
                        end
                        default: ;
                    endcase
                end
            end
            S_MUL:   len_we = 1'b1;
            S_GCRD:  gc_re  = 1'b1;
            S_GCWR:  gc_we  = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (len_we)
            len_mem[len_waddr] <= len_wdata;
        if (len_re)
            len_q_reg <= len_mem[len_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (gc_we)
            gc_mem[gc_waddr] <= gc_wdata;
        if (gc_re)
            gc_q_reg <= gc_mem[gc_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_cnt_reg    <= '0;
            count_a_reg    <= '0;
            count_c_reg    <= '0;
            count_g_reg    <= '0;
            count_t_reg    <= '0;
            base_total_reg <= '0;
            read_total_reg <= '0;
            cur_len_reg    <= '0;
            cur_gc_reg     <= '0;
            len_close_reg  <= '0;
            gc_close_reg   <= '0;
            bin_reg        <= '0;
            rem_reg        <= '0;
            dsh_reg        <= '0;
            quot_reg       <= '0;
            pct_reg        <= '0;
            step_reg       <= '0;
            q_gc_reg       <= 1'b0;
            q_hit_reg      <= 1'b0;
            res_value_reg  <= '0;
            res_done_reg   <= 1'b0;
            res_pct_reg    <= '0;
            out_valid_reg  <= 1'b0;
            out_value_reg  <= '0;
            out_done_reg   <= 1'b0;
            out_pct_reg    <= '0;
        end
        else
        begin
            // the done state handles its own load/drain of the output word
            if (rsp.ready && (state_reg != S_DONE))
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == CLR_W'(CLR_DEPTH - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        res_value_reg <= '0;
                        res_done_reg  <= 1'b0;
                        res_pct_reg   <= '0;
                        case (kind_t'(req.kind))
                            KIND_BASE:
                            begin
                                base_total_reg <= cnt_inc(base_total_reg);
                                if (is_a)
                                    count_a_reg <= cnt_inc(count_a_reg);
                                else if (is_g)
                                    count_g_reg <= cnt_inc(count_g_reg);
                                else if (is_c)
                                    count_c_reg <= cnt_inc(count_c_reg);
                                else if (is_t)
                                    count_t_reg <= cnt_inc(count_t_reg);
                                if (req.end_of_read)
                                begin
                                    if (read_total_reg != LEN_MAX)
                                        read_total_reg <= read_total_reg + 1'b1;
                                    len_close_reg <= len_next;
                                    gc_close_reg  <= gc_next;
                                    bin_reg       <= bin_next;
                                    cur_len_reg   <= '0;
                                    cur_gc_reg    <= '0;
                                    state_reg     <= S_MUL;
                                end
                                else
                                begin
                                    cur_len_reg <= len_next;
                                    cur_gc_reg  <= gc_next;
                                    state_reg   <= S_DONE;
                                end
                            end
                            KIND_LEN_BIN:
                            begin
                                q_gc_reg  <= 1'b0;
                                q_hit_reg <= len_in_range;
                                state_reg <= S_QRD;
                            end
                            KIND_GC_BIN:
                            begin
                                q_gc_reg  <= 1'b1;
                                q_hit_reg <= gc_in_range;
                                state_reg <= S_QRD;
                            end
                            default:
                            begin
                                res_value_reg <= total_sel;
                                state_reg     <= S_DONE;
                            end
                        endcase
                    end
                end
                S_QRD:
                begin
                    if (!q_hit_reg)
                        res_value_reg <= '0;
                    else if (q_gc_reg)
                        res_value_reg <= VALUE_W'(gc_q_reg);
                    else
                        res_value_reg <= VALUE_W'(len_q_reg);
                    state_reg <= S_DONE;
                end
                S_MUL:
                begin
                    // length bin write-back happens here through the write port
                    rem_reg   <= NUM_W'(gc_close_reg) * NUM_W'(GC_SCALE)
                               + NUM_W'(len_close_reg);
                    dsh_reg   <= NUM_W'({len_close_reg, 1'b0}) << (DIV_STEPS - 1);
                    quot_reg  <= '0;
                    step_reg  <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (rem_reg >= dsh_reg)
                    begin
                        rem_reg  <= rem_reg - dsh_reg;
                        quot_reg <= {quot_reg[PCT_W-2:0], 1'b1};
                    end
                    else
                        quot_reg <= {quot_reg[PCT_W-2:0], 1'b0};
                    dsh_reg  <= dsh_reg >> 1;
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == STEP_W'(DIV_STEPS - 1))
                        state_reg <= S_GCRD;
                end
                S_GCRD:
                begin
                    pct_reg   <= pct_clamp;
                    state_reg <= S_GCWR;
                end
                S_GCWR:
                begin
                    res_value_reg <= '0;
                    res_done_reg  <= 1'b1;
                    res_pct_reg   <= pct_reg;
                    state_reg     <= S_DONE;
                end
                S_DONE:
                begin
                    if (!out_valid_reg || rsp.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_value_reg <= res_value_reg;
                        out_done_reg  <= res_done_reg;
                        out_pct_reg   <= res_pct_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // a closing base always leaves the open-read counters empty
    a_close_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.kind == KIND_BASE && req.end_of_read)
            |=> (cur_len_reg == '0 && cur_gc_reg == '0))
        else $error("open-read counters not cleared at read end");

    a_gc_le_len: assert property (@(posedge clk) disable iff (!rst_n)
        cur_gc_reg <= cur_len_reg)
        else $error("GC count exceeds read length");

    a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_GCRD) |-> (quot_reg <= PCT_MAX))
        else $error("GC percent quotient above 100");

    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_DONE))
        else $error("result word loaded outside the done state");

    a_done_pct: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_done_reg) |-> (out_pct_reg == '0))
        else $error("GC percent set on a word that closed no read");

endmodule

`default_nettype wire

FILE: verif/rbcs_stats_checker.sv
// Checker: watches both channels, predicts each result word and compares field by field.
module rbcs_stats_checker
    import rbcs_pkg::*;
#(
    parameter int TOP_LENGTH_BIN = 4095
) (
    input  logic clk,
    input  logic rst_n,
    rbcs_in_if   req,
    rbcs_out_if  rsp,
    output int   mismatches,
    output int   outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               read_done;
        logic [PCT_W-1:0]   gc_percent;
    } stats_word_t;

    stats_word_t expected_words[$];

    logic [CNT_W-1:0] n_a, n_c, n_g, n_t, n_bases;
    logic [LEN_W-1:0] n_reads, open_len, open_gc;
    logic [BIN_W-1:0] len_bins [0:TOP_LENGTH_BIN];
    logic [BIN_W-1:0] gc_bins  [0:GC_BINS-1];

    int n_errors = 0;
    int n_waiting = 0;

    assign mismatches  = n_errors;
    assign outstanding = n_waiting;

    function automatic logic [CNT_W-1:0] bump48(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

    function automatic logic [LEN_W-1:0] bump32(input logic [LEN_W-1:0] v);
        return (v == LEN_MAX) ? v : v + 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        n_errors++;
        $display("[%0t] rsp mismatch on %s: got 0x%0h, expected 0x%0h",
                 $realtime, what, got, want);
    endtask

    // Advances the statistics by one word and returns the word the block must answer.
    function automatic stats_word_t tally_word(input kind_t k, input logic [CHAR_W-1:0] ch,
                                               input logic eor, input logic [IDX_W-1:0] idx);
        stats_word_t r;
        logic        gc_room;
        logic [63:0] len64;
        logic [63:0] pct64;
        int          bin;

        r = '0;
        case (k)
            KIND_BASE:
            begin
                // length and GC counts saturate together so GC never exceeds length
                gc_room  = (open_len != LEN_MAX);
                open_len = bump32(open_len);
                n_bases  = bump48(n_bases);
                if (ch == CH_A_UP || ch == CH_A_LO)
                    n_a = bump48(n_a);
                else if (ch == CH_G_UP || ch == CH_G_LO)
                begin
                    n_g = bump48(n_g);
                    if (gc_room)
                        open_gc = bump32(open_gc);
                end
                else if (ch == CH_C_UP || ch == CH_C_LO)
                begin
                    n_c = bump48(n_c);
                    if (gc_room)
                        open_gc = bump32(open_gc);
                end
                else if (ch == CH_T_UP || ch == CH_T_LO)
                    n_t = bump48(n_t);

                if (eor)
                begin
                    len64 = 64'(open_len);
                    bin   = (len64 > TOP_LENGTH_BIN) ? TOP_LENGTH_BIN : int'(len64);
                    n_reads       = bump32(n_reads);
                    len_bins[bin] = bump32(len_bins[bin]);
                    pct64 = (64'd200 * 64'(open_gc) + len64) / (64'd2 * len64);
                    if (pct64 > 64'(PCT_MAX))
                        pct64 = 64'(PCT_MAX);
                    gc_bins[int'(pct64)] = bump32(gc_bins[int'(pct64)]);
                    r.read_done  = 1'b1;
                    r.gc_percent = pct64[PCT_W-1:0];
                    open_len = '0;
                    open_gc  = '0;
                end
            end
            KIND_LEN_BIN:
            begin
                if (int'(idx) <= TOP_LENGTH_BIN)
                    r.value = VALUE_W'(len_bins[idx]);
            end
            KIND_GC_BIN:
            begin
                if (int'(idx) < GC_BINS)
                    r.value = VALUE_W'(gc_bins[idx]);
            end
            default:
            begin
                case (idx)
                    SEL_READS: r.value = VALUE_W'(n_reads);
                    SEL_BASES: r.value = n_bases;
                    SEL_A:     r.value = n_a;
                    SEL_C:     r.value = n_c;
                    SEL_G:     r.value = n_g;
                    SEL_T:     r.value = n_t;
                    default:   r.value = '0;
                endcase
            end
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        stats_word_t want;
        if (!rst_n)
        begin
            n_a = '0; n_c = '0; n_g = '0; n_t = '0; n_bases = '0;
            n_reads = '0; open_len = '0; open_gc = '0;
            foreach (len_bins[i])
                len_bins[i] = '0;
            foreach (gc_bins[i])
                gc_bins[i] = '0;
            expected_words.delete();
            n_waiting = 0;
        end
        else
        begin
            if (req.valid && req.ready)
                expected_words.push_back(tally_word(kind_t'(req.kind), req.base_char,
                                                    req.end_of_read, req.index));
            if (rsp.valid && rsp.ready)
            begin
                if (expected_words.size() == 0)
                    report_mismatch("word with nothing pending", rsp.value, '0);
                else
                begin
                    want = expected_words.pop_front();
                    if (rsp.value !== want.value)
                        report_mismatch("value", rsp.value, want.value);
                    if (rsp.read_done !== want.read_done)
                        report_mismatch("read_done", rsp.read_done, want.read_done);
                    if (rsp.gc_percent !== want.gc_percent)
                        report_mismatch("gc_percent", rsp.gc_percent, want.gc_percent);
                end
            end
            n_waiting = expected_words.size();
        end
    end

endmodule

FILE: verif/tb_read_base_composition_stats.sv
// Testbench top: clock, reset, base/query stimulus, output back-pressure and verdict.
module tb_read_base_composition_stats;
    timeunit 1ns;
    timeprecision 1ps;

    import rbcs_pkg::*;

    localparam int TOP_LENGTH_BIN = 4095;
    localparam int IDLE_PCT       = 38;
    localparam int RANDOM_WORDS   = 300;
    localparam int DRAIN_CYCLES   = 32;
    // covers the histogram clearing pass after reset with a wide margin
    localparam int QUIET_LIMIT    = 20000;

    logic clk;
    logic rst_n;
    logic calm;
    int   mismatches;
    int   outstanding;

    rbcs_in_if  req_ch ();
    rbcs_out_if rsp_ch ();

    read_base_composition_stats #(
        .TOP_LENGTH_BIN(TOP_LENGTH_BIN)
    ) u_top (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_ch),
        .rsp  (rsp_ch)
    );

    rbcs_stats_checker #(
        .TOP_LENGTH_BIN(TOP_LENGTH_BIN)
    ) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_ch),
        .rsp        (rsp_ch),
        .mismatches (mismatches),
        .outstanding(outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(negedge clk)
        rsp_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("[%0t] no word moved for %0d cycles", $realtime, QUIET_LIMIT);
        $display("FAILURE");
        $finish;
    end

    // Entered at a falling edge; returns at the falling edge after the word is taken.
    task automatic send_word(input kind_t k, input logic [CHAR_W-1:0] ch, input logic eor,
                             input logic [IDX_W-1:0] idx);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.kind        <= k;
        req_ch.base_char   <= ch;
        req_ch.end_of_read <= eor;
        req_ch.index       <= idx;
        do
            @(posedge clk);
        while (!req_ch.ready);
        @(negedge clk);
    endtask

    // base_char and end_of_read are don't-care on queries, so they carry noise
    task automatic send_query(input kind_t k, input logic [IDX_W-1:0] idx);
        send_word(k, CHAR_W'($urandom), 1'($urandom), idx);
    endtask

    function automatic logic [CHAR_W-1:0] pick_char();
        if ($urandom_range(0, 99) < 20)
            return CHAR_W'($urandom);
        case ($urandom_range(0, 7))
            0: return CH_A_UP;
            1: return CH_A_LO;
            2: return CH_C_UP;
            3: return CH_C_LO;
            4: return CH_G_UP;
            5: return CH_G_LO;
            6: return CH_T_UP;
            default: return CH_T_LO;
        endcase
    endfunction

    task automatic random_query();
        kind_t            k;
        logic [IDX_W-1:0] idx;
        k = kind_t'($urandom_range(KIND_LEN_BIN, KIND_TOTAL));
        if ($urandom_range(0, 99) < 20)
            idx = IDX_W'($urandom);
        else if (k == KIND_LEN_BIN)
            idx = ($urandom_range(0, 9) == 0) ? IDX_W'(TOP_LENGTH_BIN)
                                              : IDX_W'($urandom_range(1, 40));
        else if (k == KIND_GC_BIN)
            idx = IDX_W'($urandom_range(0, GC_BINS - 1));
        else
            idx = IDX_W'($urandom_range(SEL_READS, SEL_T + 2));
        send_query(k, idx);
    endtask

    task automatic send_read(input int len);
        int i;
        for (i = 0; i < len; i++)
            send_word(KIND_BASE, pick_char(), i == len - 1, IDX_W'($urandom));
    endtask

    // Mostly whole reads of short random length, with queries mixed in and
    // now and then landing inside an open read.
    task automatic random_traffic(input int n_words);
        int sent;
        int len;
        int i;
        sent = 0;
        while (sent < n_words)
        begin
            if ($urandom_range(0, 99) < 25)
            begin
                random_query();
                sent++;
            end
            else
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                  : $urandom_range(1, 12);
                for (i = 0; i < len; i++)
                begin
                    if ($urandom_range(0, 99) < 10)
                    begin
                        random_query();
                        sent++;
                    end
                    send_word(KIND_BASE, pick_char(), i == len - 1, IDX_W'($urandom));
                    sent++;
                end
            end
        end
    endtask

    initial
    begin : stimulus
        logic [IDX_W-1:0] sel;
        int               long_len;
        rst_n              = 1'b0;
        calm               = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.kind        = KIND_BASE;
        req_ch.base_char   = '0;
        req_ch.end_of_read = 1'b0;
        req_ch.index       = '0;
        rsp_ch.ready       = 1'b0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // every base letter in both cases plus two non-ACGT bytes: 4 GC of 10 -> 40%
        send_word(KIND_BASE, CH_A_UP, 1'b0, '0);
        send_word(KIND_BASE, CH_C_LO, 1'b0, '1);
        send_word(KIND_BASE, CH_G_UP, 1'b0, '0);
        send_word(KIND_BASE, CH_T_LO, 1'b0, '1);
        send_word(KIND_BASE, CH_A_LO, 1'b0, '0);
        send_word(KIND_BASE, CH_C_UP, 1'b0, '1);
        send_word(KIND_BASE, CH_G_LO, 1'b0, '0);
        send_word(KIND_BASE, CH_T_UP, 1'b0, '1);
        send_word(KIND_BASE, 8'h00, 1'b0, '0);
        send_word(KIND_BASE, 8'hFF, 1'b1, '1);
        // one-base reads hit the 100% and 0% GC bins
        send_word(KIND_BASE, CH_G_UP, 1'b1, '0);
        send_word(KIND_BASE, CH_A_LO, 1'b1, '1);
        send_query(KIND_LEN_BIN, IDX_W'(10));
        send_query(KIND_LEN_BIN, IDX_W'(TOP_LENGTH_BIN));
        send_query(KIND_GC_BIN, IDX_W'(40));
        send_query(KIND_GC_BIN, IDX_W'(PCT_MAX));
        send_query(KIND_GC_BIN, IDX_W'(GC_BINS));
        send_query(KIND_GC_BIN, '1);
        for (sel = SEL_READS; sel <= SEL_T + 1; sel++)
            send_query(KIND_TOTAL, sel);

        random_traffic(RANDOM_WORDS / 2);

        // sender holds off until the block has answered everything
        req_ch.valid <= 1'b0;
        wait (outstanding == 0);
        @(negedge clk);

        // a long read at full rate, then its length bin and the running totals
        calm = 1'b1;
        long_len = $urandom_range(150, 200);
        send_read(long_len);
        send_query(KIND_LEN_BIN, IDX_W'(long_len));
        send_query(KIND_TOTAL, SEL_READS);
        send_query(KIND_TOTAL, SEL_BASES);
        random_traffic(40);
        calm = 1'b0;

        random_traffic(RANDOM_WORDS - RANDOM_WORDS / 2);
        req_ch.valid <= 1'b0;

        wait (outstanding == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
